// File: design/stl_pkg.sv
// Shared types, tables and helper functions for the source token lexer.
`default_nettype none
package stl_pkg;

  localparam int POS_BITS = 24;
  localparam int MAX_KW = 6;
  localparam int MASK_BITS = 38;
  localparam int NOPS = 31;
  localparam int MAX_RES = 3;
  localparam logic [POS_BITS-1:0] POS_MAX = '1;
  localparam logic [MASK_BITS-1:0] MASK_RESET = 38'd402653440;

  // Token categories
  localparam logic [2:0] CAT_SYMBOL  = 3'd0;
  localparam logic [2:0] CAT_TYPE    = 3'd1;
  localparam logic [2:0] CAT_VALUE   = 3'd2;
  localparam logic [2:0] CAT_OP      = 3'd3;
  localparam logic [2:0] CAT_UNARY   = 3'd4;
  localparam logic [2:0] CAT_UNKNOWN = 3'd5;
  localparam logic [2:0] CAT_EOF     = 3'd6;

  // Type codes
  localparam logic [5:0] TY_NONE   = 6'd0;
  localparam logic [5:0] TY_I64    = 6'd1;
  localparam logic [5:0] TY_U64    = 6'd2;
  localparam logic [5:0] TY_DOUBLE = 6'd3;
  localparam logic [5:0] TY_BOOL   = 6'd4;
  localparam logic [5:0] TY_STRING = 6'd5;
  localparam logic [5:0] TY_VOID   = 6'd6;
  localparam logic [5:0] TY_OP_BASE = 6'd7;

  typedef enum logic [3:0] {
    M_IDLE, M_WORD, M_ZERO, M_DEC, M_FRAC, M_HEX, M_STR, M_OP, M_HELD, M_COMMENT, M_SKIP
  } mode_t;

  typedef struct packed {
    logic [2:0]          category;
    logic [5:0]          token_type;
    logic [POS_BITS-1:0] line_no;
    logic [POS_BITS-1:0] start_offset;
    logic [POS_BITS-1:0] token_length;
    logic                run_end;
  } res_t;

  // Operator table, in type code order
  localparam logic [7:0] OP_FIRST [NOPS] = '{
    "+", "-", "*", "/", "%", "=", ":", "+", "-", "*", "/", "%", "=", "!", "<", ">",
    "<", ">", "&", "|", "&", "!", "?", "-", ",", "(", ")", "[", "]", "{", "}"
  };
  localparam logic [7:0] OP_SECOND [NOPS] = '{
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, "=", "=", "=", "=", "=", "=", "=", "=", 8'd0, 8'd0,
    "=", "=", "&", "|", 8'd0, 8'd0, 8'd0, ">", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
  };

  function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
    return (v == POS_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  // First table entry matching both characters, or zero
  function automatic logic [5:0] op_code(input logic [7:0] a, input logic [7:0] b);
    logic [5:0] r;
    r = TY_NONE;
    for (int i = NOPS - 1; i >= 0; i--) begin
      if (OP_FIRST[i] == a && OP_SECOND[i] == b) r = TY_OP_BASE + 6'(i);
    end
    return r;
  endfunction

  function automatic logic starts_op(input logic [7:0] a);
    logic r;
    r = 1'b0;
    for (int i = 0; i < NOPS; i++) begin
      if (OP_FIRST[i] == a) r = 1'b1;
    end
    return r;
  endfunction

  function automatic res_t mk_tok(input logic [2:0] cat, input logic [5:0] ty,
                                  input logic [POS_BITS-1:0] line,
                                  input logic [POS_BITS-1:0] off,
                                  input logic [POS_BITS-1:0] len);
    res_t r;
    r.category = cat;
    r.token_type = ty;
    r.line_no = line;
    r.start_offset = off;
    r.token_length = len;
    r.run_end = 1'b0;
    return r;
  endfunction

  // Operator category: unary when marked and the following byte is not a space
  function automatic logic [2:0] op_cat(input logic [MASK_BITS-1:0] mask,
                                        input logic [5:0] code, input logic nns);
    return (mask[code] && nns) ? CAT_UNARY : CAT_OP;
  endfunction

  // Keyword lookup; bytes packed first character lowest
  function automatic logic [8:0] kw_class(input logic [8*MAX_KW-1:0] buf_w,
                                          input logic [3:0] cnt);
    logic [8:0] r;
    r = {CAT_SYMBOL, TY_NONE};
    if (cnt == 4'd3 && buf_w == (8*MAX_KW)'("tni"))    r = {CAT_TYPE, TY_I64};
    if (cnt == 4'd4 && buf_w == (8*MAX_KW)'("tniu"))   r = {CAT_TYPE, TY_U64};
    if (cnt == 4'd3 && buf_w == (8*MAX_KW)'("46i"))    r = {CAT_TYPE, TY_I64};
    if (cnt == 4'd3 && buf_w == (8*MAX_KW)'("46u"))    r = {CAT_TYPE, TY_U64};
    if (cnt == 4'd6 && buf_w == (8*MAX_KW)'("elbuod")) r = {CAT_TYPE, TY_DOUBLE};
    if (cnt == 4'd4 && buf_w == (8*MAX_KW)'("loob"))   r = {CAT_TYPE, TY_BOOL};
    if (cnt == 4'd6 && buf_w == (8*MAX_KW)'("gnirts")) r = {CAT_TYPE, TY_STRING};
    if (cnt == 4'd4 && buf_w == (8*MAX_KW)'("diov"))   r = {CAT_TYPE, TY_VOID};
    if (cnt == 4'd4 && buf_w == (8*MAX_KW)'("eurt"))   r = {CAT_VALUE, TY_BOOL};
    if (cnt == 4'd5 && buf_w == (8*MAX_KW)'("eslaf"))  r = {CAT_VALUE, TY_BOOL};
    return r;
  endfunction

endpackage
`default_nettype wire

// File: design/source_token_lexer_unit.sv
// Top level of the source token lexer: byte input, token descriptor output.
// First token closed by a byte appears in the cycle after that byte is accepted.
// Throughput: one byte per cycle while each byte closes at most one token and
//   out_stall is low; a byte producing more tokens (up to three) stalls the
//   input while the result bank drains one word per cycle.
// Reset (rst, synchronous): lexer idle, line 1, offset 0, result bank empty,
//   unary_mask back to its default.
`default_nettype none
module source_token_lexer_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [7:0]                    ch,
  input  wire logic                          last_byte,
  input  wire logic                          cfg_we,
  input  wire logic [stl_pkg::MASK_BITS-1:0] cfg_wdata,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [2:0]                         category,
  output logic [5:0]                         token_type,
  output logic [stl_pkg::POS_BITS-1:0]       line_no,
  output logic [stl_pkg::POS_BITS-1:0]       start_offset,
  output logic [stl_pkg::POS_BITS-1:0]       token_length,
  output logic                               run_end
);
  import stl_pkg::*;

  res_t       batch [MAX_RES];
  logic [1:0] batch_cnt;
  res_t       head;
  logic       ready;
  logic       load;

  assign in_stall = !ready;
  assign load = in_valid && ready;

  stl_core u_core (
    .clk, .rst, .step(load), .ch, .last_byte, .cfg_we, .cfg_wdata,
    .batch, .batch_cnt
  );

  stl_outbuf u_outbuf (
    .clk, .rst, .load, .batch, .batch_cnt, .out_stall, .out_valid, .head, .ready
  );

  // Drive result fields
  assign category = head.category;
  assign token_type = head.token_type;
  assign line_no = head.line_no;
  assign start_offset = head.start_offset;
  assign token_length = head.token_length;
  assign run_end = head.run_end;

endmodule
`default_nettype wire

// File: design/stl_core.sv
// Lexer state registers and the per-byte step logic producing a batch of tokens.
`default_nettype none
module stl_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          step,
  input  wire logic [7:0]                    ch,
  input  wire logic                          last_byte,
  input  wire logic                          cfg_we,
  input  wire logic [stl_pkg::MASK_BITS-1:0] cfg_wdata,
  output stl_pkg::res_t                      batch [stl_pkg::MAX_RES],
  output logic [1:0]                         batch_cnt
);
  import stl_pkg::*;

  mode_t                 mode, mode_next;
  logic [8*MAX_KW-1:0]   word_buffer, word_buffer_next;
  logic [3:0]            word_count, word_count_next;
  logic [7:0]            first_op_char, first_op_char_next;
  logic [5:0]            held_type, held_type_next;
  logic [POS_BITS-1:0]   line_counter, line_counter_next;
  logic [POS_BITS-1:0]   byte_counter, byte_counter_next;
  logic [POS_BITS-1:0]   tok_line, tok_line_next;
  logic [POS_BITS-1:0]   tok_off, tok_off_next;
  logic [POS_BITS-1:0]   tok_len, tok_len_next;
  logic                  halted, halted_next;
  logic [MASK_BITS-1:0]  unary_mask;

  res_t                  slot [4];
  logic [3:0]            slot_v;

  // Step: close the open token, start a new one, then close the file if asked
  always_comb begin
    logic       reproc;
    logic [5:0] t;
    logic [8:0] kc;
    mode_next = mode;
    word_buffer_next = word_buffer;
    word_count_next = word_count;
    first_op_char_next = first_op_char;
    held_type_next = held_type;
    line_counter_next = line_counter;
    byte_counter_next = byte_counter;
    tok_line_next = tok_line;
    tok_off_next = tok_off;
    tok_len_next = tok_len;
    halted_next = halted;
    slot_v = '0;
    for (int k = 0; k < 4; k++) slot[k] = mk_tok(CAT_SYMBOL, TY_NONE, '0, '0, '0);
    reproc = 1'b0;
    t = TY_NONE;
    kc = '0;
    if (!halted) begin
      if (ch != 8'd0) begin
        case (mode)
          M_IDLE: reproc = 1'b1;
          M_WORD: begin
            if (is_alpha(ch) || is_digit(ch) || ch == "_") begin
              for (int i = 0; i < MAX_KW; i++) begin
                if (word_count == 4'(i)) word_buffer_next[8*i +: 8] = ch;
              end
              if (word_count != 4'd15) word_count_next = word_count + 4'd1;
              tok_len_next = sat_inc(tok_len);
            end else begin
              kc = kw_class(word_buffer, word_count);
              slot[0] = mk_tok(kc[8:6], kc[5:0], tok_line, tok_off, tok_len);
              slot_v[0] = 1'b1;
              reproc = 1'b1;
            end
          end
          M_ZERO: begin
            if (ch == "x") begin
              mode_next = M_HEX; tok_len_next = sat_inc(tok_len);
            end else if (is_digit(ch)) begin
              mode_next = M_DEC; tok_len_next = sat_inc(tok_len);
            end else if (ch == ".") begin
              mode_next = M_FRAC; tok_len_next = sat_inc(tok_len);
            end else begin
              slot[0] = mk_tok(CAT_VALUE, TY_I64, tok_line, tok_off, tok_len);
              slot_v[0] = 1'b1;
              reproc = 1'b1;
            end
          end
          M_DEC: begin
            if (is_digit(ch)) begin
              tok_len_next = sat_inc(tok_len);
            end else if (ch == ".") begin
              mode_next = M_FRAC; tok_len_next = sat_inc(tok_len);
            end else begin
              slot[0] = mk_tok(CAT_VALUE, TY_I64, tok_line, tok_off, tok_len);
              slot_v[0] = 1'b1;
              reproc = 1'b1;
            end
          end
          M_FRAC: begin
            if (is_digit(ch)) begin
              tok_len_next = sat_inc(tok_len);
            end else begin
              slot[0] = mk_tok(CAT_VALUE, TY_DOUBLE, tok_line, tok_off, tok_len);
              slot_v[0] = 1'b1;
              reproc = 1'b1;
            end
          end
          M_HEX: begin
            if (is_hex(ch)) begin
              tok_len_next = sat_inc(tok_len);
            end else begin
              slot[0] = mk_tok(CAT_VALUE, TY_I64, tok_line, tok_off, tok_len);
              slot_v[0] = 1'b1;
              reproc = 1'b1;
            end
          end
          M_STR: begin
            tok_len_next = sat_inc(tok_len);
            if (ch == "\"") begin
              slot[0] = mk_tok(CAT_VALUE, TY_STRING, tok_line, tok_off, tok_len_next);
              slot_v[0] = 1'b1;
              mode_next = M_IDLE;
            end
          end
          M_COMMENT: begin
            if (ch == "\n") mode_next = M_IDLE;
          end
          M_OP: begin
            if (first_op_char == "/" && ch == "/") begin
              mode_next = M_COMMENT;
            end else if (op_code(first_op_char, ch) != TY_NONE) begin
              tok_len_next = sat_inc(tok_len);
              held_type_next = op_code(first_op_char, ch);
              mode_next = M_HELD;
            end else begin
              t = op_code(first_op_char, 8'd0);
              if (t != TY_NONE) begin
                slot[0] = mk_tok(op_cat(unary_mask, t, ch != " "), t, tok_line, tok_off,
                                 tok_len);
                reproc = 1'b1;
              end else begin
                slot[0] = mk_tok(CAT_UNKNOWN, TY_NONE, tok_line, tok_off, tok_len);
                mode_next = M_SKIP;
              end
              slot_v[0] = 1'b1;
            end
          end
          M_HELD: begin
            slot[0] = mk_tok(op_cat(unary_mask, held_type, ch != " "), held_type, tok_line,
                             tok_off, tok_len);
            slot_v[0] = 1'b1;
            reproc = 1'b1;
          end
          default: ;
        endcase
        // Begin a new token on this byte
        if (reproc) begin
          mode_next = M_IDLE;
          if (!(ch == " " || ch == "\t" || ch == "\r" || ch == "\n")) begin
            tok_line_next = line_counter;
            tok_off_next = byte_counter;
            tok_len_next = POS_BITS'(1);
            if (is_alpha(ch) || ch == "_") begin
              mode_next = M_WORD;
              word_buffer_next = (8*MAX_KW)'(ch);
              word_count_next = 4'd1;
            end else if (ch == "0") begin
              mode_next = M_ZERO;
            end else if (is_digit(ch)) begin
              mode_next = M_DEC;
            end else if (ch == "\"") begin
              mode_next = M_STR;
            end else if (starts_op(ch)) begin
              mode_next = M_OP;
              first_op_char_next = ch;
            end else begin
              slot[1] = mk_tok(CAT_UNKNOWN, TY_NONE, line_counter, byte_counter,
                               POS_BITS'(1));
              slot_v[1] = 1'b1;
              mode_next = M_SKIP;
            end
          end
        end
        if (ch == "\n") line_counter_next = sat_inc(line_counter);
        byte_counter_next = sat_inc(byte_counter);
      end
      // End of file: flush the open token, then the end marker
      if (ch == 8'd0 || last_byte) begin
        case (mode_next)
          M_WORD: begin
            kc = kw_class(word_buffer_next, word_count_next);
            slot[2] = mk_tok(kc[8:6], kc[5:0], tok_line_next, tok_off_next, tok_len_next);
            slot_v[2] = 1'b1;
          end
          M_ZERO, M_DEC, M_HEX: begin
            slot[2] = mk_tok(CAT_VALUE, TY_I64, tok_line_next, tok_off_next, tok_len_next);
            slot_v[2] = 1'b1;
          end
          M_FRAC: begin
            slot[2] = mk_tok(CAT_VALUE, TY_DOUBLE, tok_line_next, tok_off_next,
                             tok_len_next);
            slot_v[2] = 1'b1;
          end
          M_STR: begin
            slot[2] = mk_tok(CAT_VALUE, TY_STRING, tok_line_next, tok_off_next,
                             tok_len_next);
            slot_v[2] = 1'b1;
          end
          M_OP: begin
            t = op_code(first_op_char_next, 8'd0);
            if (t != TY_NONE) begin
              slot[2] = mk_tok(op_cat(unary_mask, t, 1'b1), t, tok_line_next, tok_off_next,
                               tok_len_next);
            end else begin
              slot[2] = mk_tok(CAT_UNKNOWN, TY_NONE, tok_line_next, tok_off_next,
                               tok_len_next);
            end
            slot_v[2] = 1'b1;
          end
          M_HELD: begin
            slot[2] = mk_tok(op_cat(unary_mask, held_type_next, 1'b1), held_type_next,
                             tok_line_next, tok_off_next, tok_len_next);
            slot_v[2] = 1'b1;
          end
          default: ;
        endcase
        slot[3] = mk_tok(CAT_EOF, TY_NONE, line_counter_next, byte_counter_next, '0);
        slot_v[3] = 1'b1;
        mode_next = M_IDLE;
        halted_next = 1'b1;
      end
    end
  end

  // Pack the candidate tokens in order, keep at most three, flag the last
  always_comb begin
    logic [1:0] n;
    n = 2'd0;
    for (int k = 0; k < MAX_RES; k++) batch[k] = mk_tok(CAT_SYMBOL, TY_NONE, '0, '0, '0);
    for (int k = 0; k < 4; k++) begin
      if (slot_v[k] && n != 2'd3) begin
        batch[n] = slot[k];
        n = n + 2'd1;
      end
    end
    if (n != 2'd0) batch[n - 2'd1].run_end = 1'b1;
    batch_cnt = n;
  end

  // Hold lexer state; advance on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      word_buffer <= '0;
      word_count <= '0;
      first_op_char <= '0;
      held_type <= '0;
      line_counter <= POS_BITS'(1);
      byte_counter <= '0;
      tok_line <= '0;
      tok_off <= '0;
      tok_len <= '0;
      halted <= 1'b0;
    end else if (step) begin
      mode <= mode_next;
      word_buffer <= word_buffer_next;
      word_count <= word_count_next;
      first_op_char <= first_op_char_next;
      held_type <= held_type_next;
      line_counter <= line_counter_next;
      byte_counter <= byte_counter_next;
      tok_line <= tok_line_next;
      tok_off <= tok_off_next;
      tok_len <= tok_len_next;
      halted <= halted_next;
    end
  end

  // Unary mask register
  always_ff @(posedge clk) begin
    if (rst) begin
      unary_mask <= MASK_RESET;
    end else if (cfg_we) begin
      unary_mask <= cfg_wdata;
    end
  end

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted) else $error("halt flag cleared without reset");
  a_halted_no_tokens: assert property (@(posedge clk) disable iff (rst)
    halted |-> batch_cnt == 2'd0) else $error("tokens produced after end of file");
  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    line_counter != '0) else $error("line counter reached zero");

endmodule
`default_nettype wire

// File: design/stl_outbuf.sv
// Result register bank: holds one byte's tokens, drains one word per unstalled cycle.
`default_nettype none
module stl_outbuf (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load,
  input  wire stl_pkg::res_t batch [stl_pkg::MAX_RES],
  input  wire logic [1:0]    batch_cnt,
  input  wire logic          out_stall,
  output logic               out_valid,
  output stl_pkg::res_t      head,
  output logic               ready
);
  import stl_pkg::*;

  res_t       ent [MAX_RES];
  logic [1:0] cnt;
  logic [1:0] idx;
  logic       pop;

  assign out_valid = idx < cnt;
  assign head = ent[idx];
  assign pop = out_valid && !out_stall;
  // Take a new batch when empty or when the last held word leaves now
  assign ready = !out_valid || (pop && idx == cnt - 2'd1);

  // Count and read pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      idx <= '0;
    end else if (load) begin
      cnt <= batch_cnt;
      idx <= '0;
    end else if (pop) begin
      if (idx == cnt - 2'd1) begin
        cnt <= '0;
        idx <= '0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      for (int k = 0; k < MAX_RES; k++) ent[k] <= batch[k];
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> (!out_valid || (pop && idx == cnt - 2'd1)))
    else $error("batch loaded over undelivered words");
  a_keep_draining: assert property (@(posedge clk) disable iff (rst)
    (pop && idx != cnt - 2'd1 && !load) |=> out_valid)
    else $error("batch dropped before its last word");
  a_last_marked: assert property (@(posedge clk) disable iff (rst)
    (out_valid && idx == cnt - 2'd1) |-> head.run_end)
    else $error("final word of a batch lacks run_end");
  a_inner_unmarked: assert property (@(posedge clk) disable iff (rst)
    (out_valid && idx != cnt - 2'd1) |-> !head.run_end)
    else $error("run_end set before last word");

endmodule
`default_nettype wire

// File: tb/sv/source_token_lexer_unit_test.sv
// Self-checking testbench for the source token lexer: byte stream in, token descriptors out.
`timescale 1ns / 100ps
`default_nettype none
module source_token_lexer_unit_test;
  import stl_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] ch = 8'd0;
  logic last_byte = 1'b0;
  logic cfg_we = 1'b0;
  logic [MASK_BITS-1:0] cfg_wdata = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] category;
  logic [5:0] token_type;
  logic [POS_BITS-1:0] line_no, start_offset, token_length;
  logic run_end;

  source_token_lexer_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .ch(ch), .last_byte(last_byte),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_stall(out_stall),
    .category(category), .token_type(token_type), .line_no(line_no),
    .start_offset(start_offset), .token_length(token_length), .run_end(run_end)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Lexer state mirrored for prediction
  mode_t lmode = M_IDLE;
  logic [8*MAX_KW-1:0] wbuf;
  logic [3:0] wcnt;
  logic [7:0] opc;
  logic [5:0] held_code;
  logic [POS_BITS-1:0] cur_line = 1, cur_off = 0, tk_line, tk_off, tk_len;
  bit halted = 0;
  logic [MASK_BITS-1:0] unary_bits = MASK_RESET;

  res_t step_tokens[$];
  res_t pending_tokens[$];
  int errors = 0, bytes_sent = 0, tokens_seen = 0;
  int tx_max = 0, rx_max = 0, rx_hold = 0, rx_wait = 0;
  byte unsigned text_q[$];

  string kw_w[10] = '{"int", "uint", "i64", "u64", "double", "bool", "string", "void",
                      "true", "false"};
  logic [2:0] kw_cat[10] = '{CAT_TYPE, CAT_TYPE, CAT_TYPE, CAT_TYPE, CAT_TYPE, CAT_TYPE,
                             CAT_TYPE, CAT_TYPE, CAT_VALUE, CAT_VALUE};
  logic [5:0] kw_ty[10] = '{TY_I64, TY_U64, TY_I64, TY_U64, TY_DOUBLE, TY_BOOL, TY_STRING,
                            TY_VOID, TY_BOOL, TY_BOOL};

  function automatic logic [POS_BITS-1:0] bump(input logic [POS_BITS-1:0] v);
    return (v == POS_MAX) ? v : v + 1'b1;
  endfunction

  function automatic bit digit_c(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit alpha_c(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit hexd_c(input logic [7:0] c);
    return digit_c(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic bit ws_c(input logic [7:0] c);
    return c == " " || c == 8'h09 || c == 8'h0d || c == 8'h0a;
  endfunction

  function automatic logic [5:0] find_operator(input logic [7:0] a, input logic [7:0] b);
    for (int i = 0; i < NOPS; i++)
      if (OP_FIRST[i] == a && OP_SECOND[i] == b) return TY_OP_BASE + 6'(i);
    return TY_NONE;
  endfunction

  function automatic bit opens_operator(input logic [7:0] a);
    for (int i = 0; i < NOPS; i++)
      if (OP_FIRST[i] == a) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void add_token(input logic [2:0] cat, input logic [5:0] ty,
                                    input logic [POS_BITS-1:0] ln,
                                    input logic [POS_BITS-1:0] off,
                                    input logic [POS_BITS-1:0] len);
    res_t r;
    r.category = cat;
    r.token_type = ty;
    r.line_no = ln;
    r.start_offset = off;
    r.token_length = len;
    r.run_end = 1'b0;
    if (step_tokens.size() < MAX_RES) step_tokens.insert(step_tokens.size(), r);
  endfunction

  function automatic void add_current(input logic [2:0] cat, input logic [5:0] ty);
    add_token(cat, ty, tk_line, tk_off, tk_len);
  endfunction

  function automatic void add_operator(input logic [5:0] code, input bit next_not_space);
    add_current((unary_bits[code] && next_not_space) ? CAT_UNARY : CAT_OP, code);
  endfunction

  // Classify the collected word against keywords and type words
  function automatic void add_word();
    logic [8*MAX_KW-1:0] p;
    for (int k = 0; k < 10; k++) begin
      if (kw_w[k].len() != wcnt || wcnt > MAX_KW) continue;
      p = '0;
      for (int i = 0; i < kw_w[k].len(); i++) p[8*i +: 8] = kw_w[k][i];
      if (p == wbuf) begin
        add_current(kw_cat[k], kw_ty[k]);
        return;
      end
    end
    add_current(CAT_SYMBOL, TY_NONE);
  endfunction

  // Advance the mirrored lexer by one nonzero byte
  function automatic void lex_byte(input logic [7:0] c);
    bit again;
    logic [5:0] t;
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      case (lmode)
        M_IDLE: if (!ws_c(c)) begin
          tk_line = cur_line;
          tk_off = cur_off;
          tk_len = 1;
          if (alpha_c(c) || c == "_") begin
            lmode = M_WORD;
            wbuf = '0;
            wbuf[7:0] = c;
            wcnt = 1;
          end else if (c == "0") lmode = M_ZERO;
          else if (digit_c(c)) lmode = M_DEC;
          else if (c == "\"") lmode = M_STR;
          else if (opens_operator(c)) begin
            opc = c;
            lmode = M_OP;
          end else begin
            add_current(CAT_UNKNOWN, TY_NONE);
            lmode = M_SKIP;
          end
        end
        M_WORD: if (alpha_c(c) || digit_c(c) || c == "_") begin
          if (wcnt < MAX_KW) wbuf[8*wcnt +: 8] = c;
          if (wcnt < 15) wcnt++;
          tk_len = bump(tk_len);
        end else begin
          add_word();
          lmode = M_IDLE;
          again = 1'b1;
        end
        M_ZERO: if (c == "x") begin
          lmode = M_HEX;
          tk_len = bump(tk_len);
        end else if (digit_c(c)) begin
          lmode = M_DEC;
          tk_len = bump(tk_len);
        end else if (c == ".") begin
          lmode = M_FRAC;
          tk_len = bump(tk_len);
        end else begin
          add_current(CAT_VALUE, TY_I64);
          lmode = M_IDLE;
          again = 1'b1;
        end
        M_DEC: if (digit_c(c)) tk_len = bump(tk_len);
        else if (c == ".") begin
          lmode = M_FRAC;
          tk_len = bump(tk_len);
        end else begin
          add_current(CAT_VALUE, TY_I64);
          lmode = M_IDLE;
          again = 1'b1;
        end
        M_FRAC: if (digit_c(c)) tk_len = bump(tk_len);
        else begin
          add_current(CAT_VALUE, TY_DOUBLE);
          lmode = M_IDLE;
          again = 1'b1;
        end
        M_HEX: if (hexd_c(c)) tk_len = bump(tk_len);
        else begin
          add_current(CAT_VALUE, TY_I64);
          lmode = M_IDLE;
          again = 1'b1;
        end
        M_STR: begin
          tk_len = bump(tk_len);
          if (c == "\"") begin
            add_current(CAT_VALUE, TY_STRING);
            lmode = M_IDLE;
          end
        end
        M_COMMENT: if (c == 8'h0a) lmode = M_IDLE;
        M_OP: if (opc == "/" && c == "/") lmode = M_COMMENT;
        else begin
          t = find_operator(opc, c);
          if (t != TY_NONE) begin
            tk_len = bump(tk_len);
            held_code = t;
            lmode = M_HELD;
          end else begin
            t = find_operator(opc, 8'd0);
            if (t != TY_NONE) begin
              add_operator(t, c != " ");
              lmode = M_IDLE;
              again = 1'b1;
            end else begin
              add_current(CAT_UNKNOWN, TY_NONE);
              lmode = M_SKIP;
            end
          end
        end
        M_HELD: begin
          add_operator(held_code, c != " ");
          lmode = M_IDLE;
          again = 1'b1;
        end
        default: ;
      endcase
    end
  endfunction

  // Flush any open token and add the end token
  function automatic void close_file();
    logic [5:0] t;
    case (lmode)
      M_WORD: add_word();
      M_ZERO, M_DEC, M_HEX: add_current(CAT_VALUE, TY_I64);
      M_FRAC: add_current(CAT_VALUE, TY_DOUBLE);
      M_STR: add_current(CAT_VALUE, TY_STRING);
      M_OP: begin
        t = find_operator(opc, 8'd0);
        if (t != TY_NONE) add_operator(t, 1'b1);
        else add_current(CAT_UNKNOWN, TY_NONE);
      end
      M_HELD: add_operator(held_code, 1'b1);
      default: ;
    endcase
    add_token(CAT_EOF, TY_NONE, cur_line, cur_off, '0);
    lmode = M_IDLE;
    halted = 1'b1;
  endfunction

  function automatic void predict_byte(input logic [7:0] c, input logic lst);
    if (halted) return;
    step_tokens.delete();
    if (c != 8'd0) begin
      lex_byte(c);
      if (c == 8'h0a) cur_line = bump(cur_line);
      cur_off = bump(cur_off);
    end
    if (c == 8'd0 || lst) close_file();
    if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].run_end = 1'b1;
    foreach (step_tokens[i]) pending_tokens.insert(pending_tokens.size(), step_tokens[i]);
  endfunction

  // Offer one byte and hold it until accepted, then idle a random gap
  task automatic send_byte(input logic [7:0] c, input logic lst);
    int gap;
    @(negedge clk);
    in_valid = 1'b1;
    ch = c;
    last_byte = lst;
    do @(posedge clk); while (in_stall);
    predict_byte(c, lst);
    bytes_sent++;
    gap = $urandom_range(0, tx_max);
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  task automatic send_queue();
    while (text_q.size() > 0) send_byte(text_q.pop_front(), 1'b0);
  endtask

  // Drop valid and wait for every expected token, plus a margin
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_mask(input logic [MASK_BITS-1:0] v);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    unary_bits = v;
  endtask

  function automatic byte unsigned pick_ws();
    case ($urandom_range(0, 3))
      0: return 8'h20;
      1: return 8'h09;
      2: return 8'h0d;
      default: return 8'h0a;
    endcase
  endfunction

  // Append one byte to the text being built
  function automatic void add_byte(input byte unsigned b);
    text_q.insert(text_q.size(), b);
  endfunction

  // Queue one well-formed token or a line comment; returns 1 for an operator
  function automatic bit make_token();
    int kind, n;
    byte unsigned b;
    string s;
    kind = $urandom_range(0, 9);
    if (kind < 3) begin
      if ($urandom_range(0, 1)) begin
        s = kw_w[$urandom_range(0, 9)];
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
      end else begin
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(0, i == 0 ? 2 : 3))
            0: b = 8'("a" + $urandom_range(0, 25));
            1: b = 8'("A" + $urandom_range(0, 25));
            2: b = "_";
            default: b = 8'("0" + $urandom_range(0, 9));
          endcase
          add_byte(b);
        end
      end
      return 1'b0;
    end else if (kind < 5) begin
      case ($urandom_range(0, 3))
        0: add_byte("0");
        1: begin
          add_byte("0");
          add_byte("x");
          repeat ($urandom_range(0, 4))
            add_byte($urandom_range(0, 1) ? 8'("0" + $urandom_range(0, 9))
                                          : 8'("A" + $urandom_range(0, 5)));
        end
        2: repeat ($urandom_range(1, 5)) add_byte(8'("0" + $urandom_range(0, 9)));
        default: begin
          repeat ($urandom_range(1, 3)) add_byte(8'("0" + $urandom_range(0, 9)));
          add_byte(".");
          repeat ($urandom_range(0, 3)) add_byte(8'("0" + $urandom_range(0, 9)));
        end
      endcase
      return 1'b0;
    end else if (kind == 5) begin
      add_byte("\"");
      repeat ($urandom_range(0, 6)) begin
        do b = 8'($urandom_range(1, 255)); while (b == "\"");
        add_byte(b);
      end
      add_byte("\"");
      return 1'b0;
    end else if (kind == 6) begin
      add_byte("/");
      add_byte("/");
      repeat ($urandom_range(0, 6)) begin
        do b = 8'($urandom_range(1, 255)); while (b == 8'h0a);
        add_byte(b);
      end
      add_byte(8'h0a);
      return 1'b0;
    end
    n = $urandom_range(0, NOPS - 1);
    add_byte(OP_FIRST[n]);
    if (OP_SECOND[n] != 8'd0) add_byte(OP_SECOND[n]);
    return 1'b1;
  endfunction

  // Random token stream; tokens touch only where exactly one side is an operator
  task automatic send_random(input int count);
    int target;
    bit prev_op, cur_op;
    target = bytes_sent + count;
    prev_op = 1'b0;
    while (bytes_sent < target) begin
      text_q.delete();
      cur_op = make_token();
      if (!((prev_op ^ cur_op) && $urandom_range(0, 1))) begin
        repeat ($urandom_range(1, 2)) text_q.push_front(pick_ws());
      end
      prev_op = cur_op;
      send_queue();
    end
  endtask

  task automatic test_keywords_and_literals();
    tx_max = 3;
    rx_max = 3;
    send_text("int false abcdefgh -x 0x1F 3.5 \"q\" <= //");
    send_byte(8'hff, 1'b0);
    send_byte(8'h0a, 1'b0);
    drain();
  endtask

  task automatic test_mask_clear_random();
    write_mask('0);
    tx_max = 19;
    rx_max = 19;
    send_random(140);
    drain();
  endtask

  task automatic test_mask_full_streaming();
    write_mask('1);
    tx_max = 0;
    rx_max = 0;
    send_random(120);
    drain();
  endtask

  task automatic test_output_backpressure();
    write_mask(MASK_RESET);
    tx_max = 0;
    rx_max = 2;
    rx_hold = 80;
    send_random(60);
    drain();
  endtask

  task automatic test_mask_random();
    write_mask({6'($urandom_range(0, 63)), 32'($urandom())});
    tx_max = 19;
    rx_max = 19;
    send_random(110);
    drain();
  endtask

  // A lone colon kills the rest of the file; only the end token follows
  task automatic test_lone_colon_and_end();
    tx_max = 2;
    send_text("a : 1 @ b");
    send_byte(8'd0, 1'b1);
    drain();
  endtask

  // Receiver: long hold-offs and per-word random stalls
  initial begin
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_stall = 1'b1;
        rx_hold--;
      end else if (rx_wait > 0) begin
        out_stall = 1'b1;
        rx_wait--;
      end else out_stall = 1'b0;
    end
  end

  // Compare each accepted token with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      res_t e;
      tokens_seen++;
      rx_wait = $urandom_range(0, rx_max);
      if (pending_tokens.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected token cat=%0d type=%0d", category, token_type);
      end else begin
        e = pending_tokens.pop_front();
        if (e.category !== category || e.token_type !== token_type ||
            e.line_no !== line_no || e.start_offset !== start_offset ||
            e.token_length !== token_length || e.run_end !== run_end) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp %0d/%0d L%0d @%0d n%0d e%0d got %0d/%0d L%0d @%0d n%0d e%0d",
                     e.category, e.token_type, e.line_no, e.start_offset, e.token_length,
                     e.run_end, category, token_type, line_no, start_offset, token_length,
                     run_end);
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_keywords_and_literals();
    test_mask_clear_random();
    test_mask_full_streaming();
    test_output_backpressure();
    test_mask_random();
    test_lone_colon_and_end();
    repeat (10) @(posedge clk);
    errors += pending_tokens.size();
    $display("covered %0d source bytes, %0d tokens checked, four unary mask settings",
             bytes_sent, tokens_seen);
    if (errors == 0) $display("source_token_lexer_unit_test: clean");
    else $display("source_token_lexer_unit_test: errors");
    $finish;
  end

  initial begin
    #1_000_000;
    $display("source_token_lexer_unit_test: errors");
    $finish;
  end

endmodule
`default_nettype wire
